[hw/rtl/ghf_pkg.sv]
// ----------------------------------------------------------------------------
// ghf_pkg
// Shared field widths and codes for the grid hole fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package ghf_pkg;

  // item field widths
  localparam int ELEV_W     = 24;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int FILLED_W   = 13;
  localparam int PASS_W     = 14;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_CFG_W  = 7;
  localparam int FRAC_W     = 9;
  localparam int SPAN_W     = 4;

  // window mean arithmetic (span is at most 15, so at most 225 cells)
  localparam int SUM_W      = 32;
  localparam int WCNT_W     = 8;
  localparam int DIV_W      = 32;
  localparam int DCNT_W     = 5;
  localparam int REM_W      = 9;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // fill status codes
  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE_MISSING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ALL_MISSING  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_SWEEP_LIMIT  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SPAN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_SPAN = 3'd5;

  // register reset values
  localparam logic [DIM_CFG_W-1:0] GRID_DIM_RESET   = 7'd64;
  localparam logic signed [ELEV_W-1:0] MARKER_RESET = -24'sd159984;
  localparam logic [FRAC_W-1:0]    MAX_FRAC_RESET   = 9'd128;
  localparam logic [SPAN_W-1:0]    RING_SPAN_RESET  = 4'd5;
  localparam logic [SPAN_W-1:0]    SWEEP_SPAN_RESET = 4'd3;

endpackage

`default_nettype wire

[hw/rtl/grid_hole_fill_by_window_mean.sv]
// ----------------------------------------------------------------------------
// grid_hole_fill_by_window_mean
// Elevation grid in RAM with onion-peel hole filling by window means.
// ----------------------------------------------------------------------------
// Usage:
//  An item is taken when start_i is high and busy_o is low. Its one result
//  shows on the result ports, flagged by done_o for a single cycle; the
//  receiver cannot stall it.
//  Write item: result in the cycle after acceptance, next item may follow at once.
//  Read item: ST_READ takes the registered RAM read; the result is registered.
//  Fill item: a sequencer walks the grid through the single RAM port and one
//  shared bit-serial divider. A scan reads every active cell; each visited
//  missing cell takes span*span window reads, then 32 divider steps if any
//  read was valid. A fill that is not rejected does the first scan, the ring
//  walk and a scan, then for each of its S sweep passes a raster walk and a
//  scan; busy_o stays high the whole time.
//  Configuration writes (cfg_we_i) take effect at once and are expected only
//  while busy_o is low. At reset the registers take their default values
//  and both totals clear; the grid RAM holds nothing defined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_hole_fill_by_window_mean #(
  parameter int MAX_ROWS         = 64,
  parameter int MAX_COLS         = 64,
  parameter int SWEEP_PASS_LIMIT = 10000
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [ghf_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [ghf_pkg::IDX_W-1:0]        row_index_i,
  input  wire logic [ghf_pkg::IDX_W-1:0]        col_index_i,
  input  wire logic signed [ghf_pkg::ELEV_W-1:0] elevation_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [ghf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ghf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                                  done_o,
  output logic signed [ghf_pkg::ELEV_W-1:0]     cell_value_o,
  output logic [ghf_pkg::STATUS_W-1:0]          status_o,
  output logic [ghf_pkg::FILLED_W-1:0]          filled_count_o,
  output logic [ghf_pkg::PASS_W-1:0]            pass_count_o
);

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int AW      = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * (2 ** COL_W);
  localparam int RDIM_W  = $clog2(MAX_ROWS + 1);
  localparam int CDIM_W  = $clog2(MAX_COLS + 1);
  localparam int PW      = ((ROW_W > COL_W) ? ROW_W : COL_W) + 5;
  localparam int CELLS_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int MW      = CELLS_W + ghf_pkg::FRAC_W;
  localparam int LIM_W   = $clog2(SWEEP_PASS_LIMIT + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_INIT, ST_SCAN_ADDR, ST_SCAN_DATA, ST_CHECK,
    ST_CENTER, ST_RING, ST_VISIT, ST_CELL, ST_WIN, ST_WIN_END, ST_DIVSET,
    ST_DIV, ST_DIVEND, ST_STORE, ST_ADV, ST_SWEEP
  } state_e;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ghf_pkg::DIM_CFG_W-1:0]      grid_rows_q, grid_cols_q;
  logic signed [ghf_pkg::ELEV_W-1:0]  marker_q;
  logic [ghf_pkg::FRAC_W-1:0]         frac_q;
  logic [ghf_pkg::SPAN_W-1:0]         rspan_q, sspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= ghf_pkg::GRID_DIM_RESET;
      grid_cols_q <= ghf_pkg::GRID_DIM_RESET;
      marker_q    <= ghf_pkg::MARKER_RESET;
      frac_q      <= ghf_pkg::MAX_FRAC_RESET;
      rspan_q     <= ghf_pkg::RING_SPAN_RESET;
      sspan_q     <= ghf_pkg::SWEEP_SPAN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ghf_pkg::CFG_GRID_ROWS:  grid_rows_q <= cfg_wdata_i[ghf_pkg::DIM_CFG_W-1:0];
        ghf_pkg::CFG_GRID_COLS:  grid_cols_q <= cfg_wdata_i[ghf_pkg::DIM_CFG_W-1:0];
        ghf_pkg::CFG_MARKER:     marker_q    <= $signed(cfg_wdata_i[ghf_pkg::ELEV_W-1:0]);
        ghf_pkg::CFG_MAX_FRAC:   frac_q      <= cfg_wdata_i[ghf_pkg::FRAC_W-1:0];
        ghf_pkg::CFG_RING_SPAN:  rspan_q     <= cfg_wdata_i[ghf_pkg::SPAN_W-1:0];
        ghf_pkg::CFG_SWEEP_SPAN: sspan_q     <= cfg_wdata_i[ghf_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // active grid size, saturated into range
  logic [RDIM_W-1:0] act_rows;
  logic [CDIM_W-1:0] act_cols;

  always_comb begin
    if (grid_rows_q == '0) begin
      act_rows = RDIM_W'(1);
    end else if (int'(grid_rows_q) > MAX_ROWS) begin
      act_rows = RDIM_W'(MAX_ROWS);
    end else begin
      act_rows = RDIM_W'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      act_cols = CDIM_W'(1);
    end else if (int'(grid_cols_q) > MAX_COLS) begin
      act_cols = CDIM_W'(MAX_COLS);
    end else begin
      act_cols = CDIM_W'(grid_cols_q);
    end
  end

  logic signed [PW-1:0] rows_s, cols_s;
  assign rows_s = $signed(PW'(act_rows));
  assign cols_s = $signed(PW'(act_cols));

  function automatic logic in_grid(input logic signed [PW-1:0] r,
                                   input logic signed [PW-1:0] c,
                                   input logic signed [PW-1:0] nr,
                                   input logic signed [PW-1:0] nc);
    return (r >= 0) && (r < nr) && (c >= 0) && (c < nc);
  endfunction

  // --------------------------------------------------------------------------
  // sequencer registers
  // --------------------------------------------------------------------------
  state_e                          state_q;
  logic                            done_q, read_hit_q;
  logic signed [ghf_pkg::ELEV_W-1:0] cell_value_q, mean_q;
  logic [ghf_pkg::STATUS_W-1:0]    status_q;
  logic [ghf_pkg::FILLED_W-1:0]    filled_q;
  logic [ghf_pkg::PASS_W-1:0]      pass_q;
  logic [CELLS_W-1:0]              cells_q, miss_q;
  logic                            found_q, scan_sweep_q, phase_sweep_q;
  logic signed [PW-1:0]            r1_q, r2_q, c1_q, c2_q, rc_q, cc_q, k_q;
  logic signed [PW-1:0]            pos_r_q, pos_c_q;
  logic [1:0]                      side_q;
  logic [LIM_W-1:0]                cnt_q;
  // window walk
  logic signed [PW-1:0]            win_r_q, win_c_q, base_c_q;
  logic [ghf_pkg::SPAN_W-1:0]      wi_q, wj_q;
  logic                            pend_q;
  logic signed [ghf_pkg::SUM_W-1:0] sum_q;
  logic [ghf_pkg::WCNT_W-1:0]      n_q;
  // shared divider
  logic [ghf_pkg::DIV_W-1:0]       div_num_q;
  logic [ghf_pkg::REM_W-1:0]       div_rem_q, div_den_q;
  logic [ghf_pkg::DCNT_W-1:0]      div_cnt_q;
  logic                            div_neg_q;

  // RAM port
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [ghf_pkg::ELEV_W-1:0]  mem_wdata, mem_rdata;
  logic signed [ghf_pkg::ELEV_W-1:0] rdata_s;
  assign rdata_s = $signed(mem_rdata);

  logic in_mem;
  assign in_mem = (int'(row_index_i) < MAX_ROWS) && (int'(col_index_i) < MAX_COLS);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = mean_q;
    mem_addr  = {pos_r_q[ROW_W-1:0], pos_c_q[COL_W-1:0]};
    case (state_q)
      ST_IDLE: begin
        mem_addr  = {ROW_W'(row_index_i), COL_W'(col_index_i)};
        mem_wdata = elevation_i;
        mem_we    = start_i && (kind_i == ghf_pkg::KIND_WRITE) && in_mem;
      end
      ST_WIN:   mem_addr = {win_r_q[ROW_W-1:0], win_c_q[COL_W-1:0]};
      ST_STORE: mem_we = 1'b1;
      default: ;
    endcase
  end

  ghf_ram #(
    .WIDTH (ghf_pkg::ELEV_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic [ghf_pkg::SPAN_W-1:0] span_c;
  assign span_c = phase_sweep_q ? sspan_q : rspan_q;

  logic signed [PW-1:0] half_s;
  assign half_s = $signed(PW'(span_c >> 1));

  // window accumulate of the read issued last cycle
  logic                             acc_take;
  logic signed [ghf_pkg::SUM_W-1:0] sum_d;
  logic [ghf_pkg::WCNT_W-1:0]       n_d;
  assign acc_take = pend_q && (rdata_s != marker_q);
  assign sum_d    = acc_take ? sum_q + ghf_pkg::SUM_W'(rdata_s) : sum_q;
  assign n_d      = acc_take ? n_q + ghf_pkg::WCNT_W'(1) : n_q;

  logic win_last_c, win_last_r;
  assign win_last_c = (wj_q == span_c - ghf_pkg::SPAN_W'(1));
  assign win_last_r = (wi_q == span_c - ghf_pkg::SPAN_W'(1));

  // rounding divide setup: q = (2|sum| + n) / 2n
  logic [ghf_pkg::DIV_W-1:0] sum_abs;
  assign sum_abs = sum_q[ghf_pkg::SUM_W-1] ? ghf_pkg::DIV_W'(-sum_q)
                                           : ghf_pkg::DIV_W'(sum_q);

  // restoring divide step
  logic [ghf_pkg::REM_W:0]   rem_sh;
  logic                      rem_ge;
  assign rem_sh = {div_rem_q, div_num_q[ghf_pkg::DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};

  logic signed [ghf_pkg::ELEV_W-1:0] mean_c;
  assign mean_c = div_neg_q ? -$signed(div_num_q[ghf_pkg::ELEV_W-1:0])
                            : $signed(div_num_q[ghf_pkg::ELEV_W-1:0]);

  logic [MW-1:0] miss_x256, frac_x_cells;
  assign miss_x256    = MW'(miss_q) << 8;
  assign frac_x_cells = MW'(frac_q) * MW'(cells_q);

  logic scan_last_c, scan_last_r;
  assign scan_last_c = (pos_c_q == cols_s - PW'(1));
  assign scan_last_r = (pos_r_q == rows_s - PW'(1));

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      done_q        <= 1'b0;
      read_hit_q    <= 1'b0;
      cell_value_q  <= '0;
      mean_q        <= '0;
      status_q      <= ghf_pkg::STATUS_OK;
      filled_q      <= '0;
      pass_q        <= '0;
      cells_q       <= '0;
      miss_q        <= '0;
      found_q       <= 1'b0;
      scan_sweep_q  <= 1'b0;
      phase_sweep_q <= 1'b0;
      r1_q          <= '0;
      r2_q          <= '0;
      c1_q          <= '0;
      c2_q          <= '0;
      rc_q          <= '0;
      cc_q          <= '0;
      k_q           <= '0;
      pos_r_q       <= '0;
      pos_c_q       <= '0;
      side_q        <= '0;
      cnt_q         <= '0;
      win_r_q       <= '0;
      win_c_q       <= '0;
      base_c_q      <= '0;
      wi_q          <= '0;
      wj_q          <= '0;
      pend_q        <= 1'b0;
      sum_q         <= '0;
      n_q           <= '0;
      div_num_q     <= '0;
      div_rem_q     <= '0;
      div_den_q     <= '0;
      div_cnt_q     <= '0;
      div_neg_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        // take an item
        ST_IDLE: begin
          if (start_i) begin
            cell_value_q <= '0;
            status_q     <= ghf_pkg::STATUS_OK;
            case (kind_i)
              ghf_pkg::KIND_FILL: begin
                filled_q <= '0;
                pass_q   <= '0;
                state_q  <= ST_INIT;
              end
              ghf_pkg::KIND_READ: begin
                read_hit_q <= in_mem;
                state_q    <= ST_READ;
              end
              default: done_q <= 1'b1;
            endcase
          end
        end

        ST_READ: begin
          cell_value_q <= read_hit_q ? rdata_s : '0;
          done_q       <= 1'b1;
          state_q      <= ST_IDLE;
        end

        // first scan: missing count and bounding box
        ST_INIT: begin
          cells_q      <= CELLS_W'(act_rows) * CELLS_W'(act_cols);
          miss_q       <= '0;
          found_q      <= 1'b0;
          pos_r_q      <= '0;
          pos_c_q      <= '0;
          scan_sweep_q <= 1'b0;
          state_q      <= ST_SCAN_ADDR;
        end

        ST_SCAN_ADDR: state_q <= ST_SCAN_DATA;

        ST_SCAN_DATA: begin
          if (rdata_s == marker_q) begin
            miss_q <= miss_q + CELLS_W'(1);
          end else begin
            if (!found_q) r1_q <= pos_r_q;
            found_q <= 1'b1;
            r2_q    <= pos_r_q;
            if (!found_q || pos_c_q < c1_q) c1_q <= pos_c_q;
            if (!found_q || pos_c_q > c2_q) c2_q <= pos_c_q;
          end
          if (scan_last_c) begin
            pos_c_q <= '0;
            if (scan_last_r) begin
              state_q <= scan_sweep_q ? ST_SWEEP : ST_CHECK;
            end else begin
              pos_r_q <= pos_r_q + PW'(1);
              state_q <= ST_SCAN_ADDR;
            end
          end else begin
            pos_c_q <= pos_c_q + PW'(1);
            state_q <= ST_SCAN_ADDR;
          end
        end

        // reject checks
        ST_CHECK: begin
          if (miss_q == '0) begin
            status_q <= ghf_pkg::STATUS_NONE_MISSING;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (miss_q == cells_q) begin
            status_q <= ghf_pkg::STATUS_ALL_MISSING;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (miss_x256 > frac_x_cells) begin
            status_q <= ghf_pkg::STATUS_TOO_MANY;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_CENTER;
          end
        end

        ST_CENTER: begin
          rc_q    <= ((r2_q - r1_q) >>> 1) + r1_q;
          cc_q    <= ((c2_q - c1_q) >>> 1) + c1_q;
          k_q     <= PW'(1);
          state_q <= ST_RING;
        end

        // start a ring, or move on to the raster sweeps
        ST_RING: begin
          if ((rc_q - k_q < 0) && (rc_q + k_q >= rows_s) &&
              (cc_q - k_q < 0) && (cc_q + k_q >= cols_s)) begin
            cnt_q        <= '0;
            miss_q       <= '0;
            pos_r_q      <= '0;
            pos_c_q      <= '0;
            scan_sweep_q <= 1'b1;
            state_q      <= ST_SCAN_ADDR;
          end else begin
            side_q        <= 2'd0;
            pos_r_q       <= rc_q - k_q;
            pos_c_q       <= cc_q - k_q;
            phase_sweep_q <= 1'b0;
            state_q       <= ST_VISIT;
          end
        end

        // visit one position: read the cell when inside the grid
        ST_VISIT: begin
          state_q <= in_grid(pos_r_q, pos_c_q, rows_s, cols_s) ? ST_CELL : ST_ADV;
        end

        ST_CELL: begin
          if ((rdata_s == marker_q) && (span_c != '0)) begin
            win_r_q  <= pos_r_q - half_s;
            win_c_q  <= pos_c_q - half_s;
            base_c_q <= pos_c_q - half_s;
            wi_q     <= '0;
            wj_q     <= '0;
            pend_q   <= 1'b0;
            sum_q    <= '0;
            n_q      <= '0;
            state_q  <= ST_WIN;
          end else begin
            state_q <= ST_ADV;
          end
        end

        // window walk, one read per cycle, each read's data accumulated from the RAM's registered output
        ST_WIN: begin
          sum_q  <= sum_d;
          n_q    <= n_d;
          pend_q <= in_grid(win_r_q, win_c_q, rows_s, cols_s);
          if (win_last_c) begin
            wj_q    <= '0;
            win_c_q <= base_c_q;
            if (win_last_r) begin
              state_q <= ST_WIN_END;
            end else begin
              wi_q    <= wi_q + ghf_pkg::SPAN_W'(1);
              win_r_q <= win_r_q + PW'(1);
            end
          end else begin
            wj_q    <= wj_q + ghf_pkg::SPAN_W'(1);
            win_c_q <= win_c_q + PW'(1);
          end
        end

        ST_WIN_END: begin
          sum_q   <= sum_d;
          n_q     <= n_d;
          pend_q  <= 1'b0;
          state_q <= ST_DIVSET;
        end

        ST_DIVSET: begin
          if (n_q == '0) begin
            state_q <= ST_ADV;
          end else begin
            div_neg_q <= sum_q[ghf_pkg::SUM_W-1];
            div_num_q <= {sum_abs[ghf_pkg::DIV_W-2:0], 1'b0} + ghf_pkg::DIV_W'(n_q);
            div_den_q <= {n_q, 1'b0};
            div_rem_q <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end

        // shared divider: one quotient bit per cycle
        ST_DIV: begin
          div_rem_q <= rem_ge ? ghf_pkg::REM_W'(rem_sh - {1'b0, div_den_q})
                              : ghf_pkg::REM_W'(rem_sh);
          div_num_q <= {div_num_q[ghf_pkg::DIV_W-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + ghf_pkg::DCNT_W'(1);
          if (div_cnt_q == ghf_pkg::DCNT_W'(ghf_pkg::DIV_W - 1)) begin
            state_q <= ST_DIVEND;
          end
        end

        ST_DIVEND: begin
          if (mean_c == marker_q) begin
            state_q <= ST_ADV;
          end else begin
            mean_q  <= mean_c;
            state_q <= ST_STORE;
          end
        end

        ST_STORE: begin
          filled_q <= filled_q + ghf_pkg::FILLED_W'(1);
          state_q  <= ST_ADV;
        end

        // next position of the ring or the raster walk
        ST_ADV: begin
          if (phase_sweep_q) begin
            if (scan_last_c) begin
              pos_c_q <= '0;
              if (scan_last_r) begin
                miss_q       <= '0;
                pos_r_q      <= '0;
                scan_sweep_q <= 1'b1;
                state_q      <= ST_SCAN_ADDR;
              end else begin
                pos_r_q <= pos_r_q + PW'(1);
                state_q <= ST_VISIT;
              end
            end else begin
              pos_c_q <= pos_c_q + PW'(1);
              state_q <= ST_VISIT;
            end
          end else begin
            state_q <= ST_VISIT;
            case (side_q)
              2'd0: begin
                if (pos_c_q == cc_q + k_q) side_q <= 2'd1;
                else pos_c_q <= pos_c_q + PW'(1);
              end
              2'd1: begin
                if (pos_r_q == rc_q + k_q) side_q <= 2'd2;
                else pos_r_q <= pos_r_q + PW'(1);
              end
              2'd2: begin
                if (pos_c_q == cc_q - k_q) side_q <= 2'd3;
                else pos_c_q <= pos_c_q - PW'(1);
              end
              default: begin
                if (pos_r_q == rc_q - k_q) begin
                  pass_q  <= pass_q + ghf_pkg::PASS_W'(1);
                  k_q     <= k_q + PW'(1);
                  state_q <= ST_RING;
                end else begin
                  pos_r_q <= pos_r_q - PW'(1);
                end
              end
            endcase
          end
        end

        // after a sweep scan: finish, give up, or sweep again
        ST_SWEEP: begin
          if (miss_q == '0) begin
            status_q <= ghf_pkg::STATUS_OK;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (cnt_q + LIM_W'(1) == LIM_W'(SWEEP_PASS_LIMIT)) begin
            status_q <= ghf_pkg::STATUS_SWEEP_LIMIT;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            cnt_q         <= cnt_q + LIM_W'(1);
            pass_q        <= pass_q + ghf_pkg::PASS_W'(1);
            phase_sweep_q <= 1'b1;
            pos_r_q       <= '0;
            pos_c_q       <= '0;
            state_q       <= ST_VISIT;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign cell_value_o   = cell_value_q;
  assign status_o       = status_q;
  assign filled_count_o = filled_q;
  assign pass_count_o   = pass_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_write_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == ghf_pkg::KIND_WRITE)
      |=> (done_o && status_o == ghf_pkg::STATUS_OK))
    else $error("write item did not answer in one cycle");

  a_reject_totals : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ghf_pkg::STATUS_NONE_MISSING ||
                status_o == ghf_pkg::STATUS_ALL_MISSING ||
                status_o == ghf_pkg::STATUS_TOO_MANY))
      |-> (filled_count_o == '0 && pass_count_o == '0))
    else $error("rejected grid reports nonzero totals");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_den_q != '0))
    else $error("divider running with zero divisor");

endmodule

`default_nettype wire

[hw/rtl/ghf_ram.sv]
// ----------------------------------------------------------------------------
// ghf_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
